/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of the literal search block.
// Each macro wraps one clocked concurrent assertion with an asynchronous reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with a caller message
`define ALS_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion with a fixed message
`define ALS_ASSERT(label, clk, rst_n, prop) \
	`ALS_ASSERT_MSG(label, clk, rst_n, prop, "als assertion failed")

`endif

/* hdl/als_pkg.sv */
// Package of the anchored literal search block: codes, constants and chain types.
// No dependencies; used by every module of the block.
`default_nettype none

package als_pkg;

	localparam int DEF_MAX_PATTERN    = 64;
	localparam int DEF_POSITION_WIDTH = 16;
	localparam int LENGTH_CAP         = 1000;
	localparam int OUT_W              = 16;

	localparam logic [7:0] CARET  = 8'h5E;
	localparam logic [7:0] DOLLAR = 8'h24;

	typedef enum logic [1:0] {
		OP_PAT_BYTE  = 2'd0,
		OP_PAT_END   = 2'd1,
		OP_TEXT_BYTE = 2'd2,
		OP_TEXT_END  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED    = 3'd0,
		ST_MATCH       = 3'd1,
		ST_NO_MATCH    = 3'd2,
		ST_BAD_PATTERN = 3'd3,
		ST_NO_PATTERN  = 3'd4,
		ST_TOO_LONG    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_SUBSTR = 2'd0,
		MODE_PREFIX = 2'd1,
		MODE_SUFFIX = 2'd2
	} mode_t;

	// broadcast to every cell
	typedef struct packed {
		logic       load;
		logic       fresh;
		logic       step;
		logic       clear;
		logic       prefix;
		logic       first;
		logic [7:0] c;
	} cell_ctrl_t;

	// pattern path, right to left
	typedef struct packed {
		logic [7:0] data;
		logic       used;
	} pat_link_t;

	// match path, left to right
	typedef struct packed {
		logic p;
		logic used;
		logic head;
	} match_link_t;

	typedef struct packed {
		status_t           status;
		logic [OUT_W-1:0]  match_start;
		logic [OUT_W-1:0]  match_end;
	} res_t;

endpackage

`default_nettype wire

/* hdl/als_cell.sv */
// One cell of the match chain: a pattern byte, its in-use bit and a partial-match bit.
// Depends on als_pkg for the control and link structs.
`default_nettype none

module als_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  als_pkg::cell_ctrl_t      ctrl,
	input  als_pkg::pat_link_t       pat_in,
	output als_pkg::pat_link_t       pat_out,
	input  als_pkg::match_link_t     match_in,
	output als_pkg::match_link_t     match_out,
	output logic                     hit
);

	logic [7:0] byte_q;
	logic       used_q;
	logic       p_q;
	logic       head;
	logic       seed;
	logic       eq;

	assign head = used_q & ~match_in.used;
	assign eq   = (byte_q == ctrl.c);
	assign seed = ctrl.prefix ? (match_in.head & ctrl.first) : head;
	assign hit  = used_q & eq & (seed | match_in.p);

	assign pat_out.data = byte_q;
	assign pat_out.used = used_q & ~ctrl.fresh;

	assign match_out.p    = p_q;
	assign match_out.used = used_q;
	assign match_out.head = head;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= pat_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			p_q    <= 1'b0;
		end else begin
			if (ctrl.load) begin
				used_q <= pat_in.used;
			end
			if (ctrl.clear) begin
				p_q <= 1'b0;
			end else if (ctrl.step) begin
				p_q <= hit;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/als_skid.sv */
// Two-entry result buffer: output register plus skid stage.
// Depends on als_pkg for the result struct.
`default_nettype none

module als_skid (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  als_pkg::res_t    push_data,
	output logic             in_ready,
	output logic             out_valid,
	output als_pkg::res_t    out_data,
	input  wire              out_ready
);

	logic          main_v_q;
	logic          skid_v_q;
	als_pkg::res_t main_q;
	als_pkg::res_t skid_q;
	logic          pop;

	assign pop       = main_v_q & out_ready;
	assign in_ready  = ~skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || pop) begin
				main_v_q <= skid_v_q | push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hdl/anchored_literal_search.sv */
// Top level of the anchored literal search block: control registers, cell chain, result buffer.
// Depends on als_pkg, als_cell and als_skid.
//
// Load a pattern one beat at a time, close it with a pattern-end beat, then stream text bytes
// and close with a text-end beat; each end beat returns one result beat. The pattern is held
// right-aligned in a row of MAX_PATTERN cells (the newest byte always in the last cell), and each
// text byte updates every cell's partial-match bit at once, so a beat of any kind is accepted in
// every cycle while the result buffer has room. The input stalls only while both entries of the
// two-deep result buffer are full. Usable pattern length is the smaller of MAX_PATTERN and 1000.
`default_nettype none

module anchored_literal_search #(
	parameter int MAX_PATTERN    = als_pkg::DEF_MAX_PATTERN,
	parameter int POSITION_WIDTH = als_pkg::DEF_POSITION_WIDTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire  [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [15:0] match_start, [31:16] match_end
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int PAT_LIMIT = (MAX_PATTERN < als_pkg::LENGTH_CAP) ? MAX_PATTERN
	                                                                : als_pkg::LENGTH_CAP;
	localparam int LW = $clog2(PAT_LIMIT + 1);
	localparam int PW = POSITION_WIDTH;
	localparam int AW = ((PW > LW) ? PW : LW) + 1;
	localparam int OW = (PW < als_pkg::OUT_W) ? PW : als_pkg::OUT_W;

	als_pkg::opcode_t opcode;
	logic             accept;
	logic             fresh;
	logic             clear_text;
	logic             step;
	logic             push;

	logic [LW-1:0]    len_q;
	logic             ovf_q;
	logic             ready_q;
	als_pkg::mode_t   mode_q;
	logic [7:0]       first_q;
	logic [PW:0]      pos_q;
	logic             found_q;
	logic [PW-1:0]    start_q;

	als_pkg::cell_ctrl_t  ctrl;
	als_pkg::pat_link_t   pat_w   [MAX_PATTERN:0];
	als_pkg::match_link_t match_w [MAX_PATTERN:0];
	logic [MAX_PATTERN-1:0] hit_w;

	logic [AW-1:0]    pos_a;
	logic [AW-1:0]    len_a;
	logic [AW-1:0]    start_a;
	logic [AW-1:0]    s_a;
	logic [AW-1:0]    e_a;
	als_pkg::status_t st;
	als_pkg::res_t    res;
	als_pkg::res_t    out_res;
	logic             skid_ready;

	assign opcode   = als_pkg::opcode_t'(s_tuser);
	assign s_tready = skid_ready;
	assign accept   = s_tvalid & skid_ready;
	assign fresh    = ready_q | (len_q == '0);
	assign step     = accept & (opcode == als_pkg::OP_TEXT_BYTE) & ready_q & ~pos_q[PW];
	assign push     = accept & ((opcode == als_pkg::OP_PAT_END) ||
	                            (opcode == als_pkg::OP_TEXT_END));
	assign clear_text = accept & (((opcode == als_pkg::OP_PAT_BYTE) & ready_q) ||
	                              (opcode == als_pkg::OP_PAT_END) ||
	                              (opcode == als_pkg::OP_TEXT_END));

	assign ctrl.load   = accept & (opcode == als_pkg::OP_PAT_BYTE) &
	                     (fresh | (len_q < LW'(PAT_LIMIT)));
	assign ctrl.fresh  = fresh;
	assign ctrl.step   = step;
	assign ctrl.clear  = clear_text;
	assign ctrl.prefix = (mode_q == als_pkg::MODE_PREFIX);
	assign ctrl.first  = (pos_q == '0);
	assign ctrl.c      = s_tdata;

	assign pat_w[MAX_PATTERN].data = s_tdata;
	assign pat_w[MAX_PATTERN].used = 1'b1;
	assign match_w[0] = '0;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		als_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pat_in    (pat_w[i+1]),
			.pat_out   (pat_w[i]),
			.match_in  (match_w[i]),
			.match_out (match_w[i+1]),
			.hit       (hit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			ready_q <= 1'b0;
			mode_q  <= als_pkg::MODE_SUBSTR;
			pos_q   <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else if (accept) begin
			if (clear_text) begin
				pos_q   <= '0;
				found_q <= 1'b0;
				start_q <= '0;
			end
			case (opcode)
				als_pkg::OP_PAT_BYTE: begin
					if (fresh) begin
						len_q   <= LW'(1);
						ovf_q   <= 1'b0;
						ready_q <= 1'b0;
					end else if (len_q < LW'(PAT_LIMIT)) begin
						len_q <= len_q + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				als_pkg::OP_PAT_END: begin
					if (len_q == '0 || ovf_q) begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						ready_q <= 1'b0;
					end else begin
						ready_q <= 1'b1;
						if (first_q == als_pkg::CARET) begin
							mode_q <= als_pkg::MODE_PREFIX;
						end else if (len_q >= LW'(2) &&
						             pat_w[MAX_PATTERN-1].data == als_pkg::DOLLAR) begin
							mode_q <= als_pkg::MODE_SUFFIX;
						end else begin
							mode_q <= als_pkg::MODE_SUBSTR;
						end
					end
				end
				als_pkg::OP_TEXT_BYTE: begin
					if (step) begin
						pos_q <= pos_q + (PW+1)'(1);
						if (mode_q == als_pkg::MODE_PREFIX && hit_w[MAX_PATTERN-1]) begin
							found_q <= 1'b1;
						end else if (mode_q == als_pkg::MODE_SUBSTR && !found_q &&
						             hit_w[MAX_PATTERN-1]) begin
							found_q <= 1'b1;
							start_q <= PW'(pos_a + AW'(1) - len_a);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && fresh) begin
			first_q <= s_tdata;
		end
	end

	assign pos_a   = AW'(pos_q[PW-1:0]);
	assign len_a   = AW'(len_q);
	assign start_a = AW'(start_q);

	always_comb begin
		st  = als_pkg::ST_NO_MATCH;
		s_a = '0;
		e_a = '0;
		if (opcode == als_pkg::OP_PAT_END) begin
			st = (len_q == '0 || ovf_q) ? als_pkg::ST_BAD_PATTERN : als_pkg::ST_ACCEPTED;
		end else if (!ready_q) begin
			st = als_pkg::ST_NO_PATTERN;
		end else if (pos_q[PW]) begin
			st = als_pkg::ST_TOO_LONG;
		end else begin
			case (mode_q)
				als_pkg::MODE_PREFIX: begin
					if (len_q == LW'(1)) begin
						st = als_pkg::ST_MATCH;
					end else if (found_q) begin
						st  = als_pkg::ST_MATCH;
						e_a = len_a - AW'(1);
					end
				end
				als_pkg::MODE_SUFFIX: begin
					if (match_w[MAX_PATTERN-1].p && pos_a >= len_a - AW'(1)) begin
						st  = als_pkg::ST_MATCH;
						s_a = pos_a - (len_a - AW'(1));
						e_a = pos_a;
					end
				end
				default: begin
					if (found_q) begin
						st  = als_pkg::ST_MATCH;
						s_a = start_a;
						e_a = start_a + len_a;
					end
				end
			endcase
		end
	end

	assign res.status      = st;
	assign res.match_start = als_pkg::OUT_W'(s_a[OW-1:0]);
	assign res.match_end   = als_pkg::OUT_W'(e_a[OW-1:0]);

	als_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.in_ready  (skid_ready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.out_ready (m_tready)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {out_res.match_end, out_res.match_start};

endmodule

`default_nettype wire

/* hdl/als_checker.sv */
// Port-level checker for anchored_literal_search, bound to the top level.
// Depends on als_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module als_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [7:0]  s_tdata,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [2:0]  m_tuser
);

	logic in_beat;
	logic end_beat;
	logic quiet_beat;

	assign in_beat    = s_tvalid && s_tready;
	assign end_beat   = in_beat && (s_tuser == als_pkg::OP_PAT_END ||
	                                s_tuser == als_pkg::OP_TEXT_END);
	assign quiet_beat = in_beat && (s_tuser == als_pkg::OP_PAT_BYTE ||
	                                s_tuser == als_pkg::OP_TEXT_BYTE) && (s_tdata == s_tdata);

	// hold a stalled result
	`ALS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// zero offsets unless a match
	`ALS_ASSERT(a_zero_offsets, clk, arst_n, m_tvalid && m_tuser != als_pkg::ST_MATCH |-> m_tdata == 32'd0)
	// end beats always produce a result
	`ALS_ASSERT(a_end_result, clk, arst_n, end_beat |=> m_tvalid)
	// byte beats never produce one while no result is pending
	`ALS_ASSERT(a_byte_silent, clk, arst_n, quiet_beat && !m_tvalid |=> !m_tvalid)

endmodule

bind anchored_literal_search als_checker u_als_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
